FILE: sv/crwp_pkg.sv
// shared types and constants for the counter rate meter with window peak
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package crwp_pkg;

  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 48;
  localparam int LIMIT_W   = 16;
  localparam int RATE_W    = 40;
  localparam int PEAK_W    = 31;
  localparam int DIVISOR_W = 31;

  // 256000 = 125 * 2^11: times 125 by shift and add, times 2^11 by appended zeros
  localparam int SCALE_ODD_W = 7;
  localparam int SCALE_SHIFT = 11;
  localparam int SCALED_W    = COUNT_W + SCALE_ODD_W;
  localparam int DVD_W       = SCALED_W + SCALE_SHIFT;

  localparam logic [LIMIT_W-1:0] STALE_RESET = 16'd2000;

  localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
  localparam logic [PEAK_W-1:0]        PEAK_MAX = {PEAK_W{1'b1}};

  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic rate_from_div;
    logic ring_write;
    logic scan_start;
    logic out_load;
  } crwp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic need_div;
    logic div_done;
    logic scan_done;
    logic out_free;
  } crwp_status_t;

endpackage

`default_nettype wire

FILE: sv/counter_rate_window_peak.sv
// top level of the counter rate meter with peak over a history window
// uses crwp_pkg, crwp_ctrl and crwp_datapath
`timescale 1ns / 1ps
`default_nettype none

// Rate meter for a cumulative counter. Each input transfer carries a counter
// sample, its timestamp and the current time (ms). A tick updates the rate in
// units per second as signed Q32.8 (truncated toward zero, saturated), stores it
// in a ring of WINDOW_DEPTH entries and returns the rate together with the
// ceiling of the largest ring entry (negatives read as 0). Samples older than
// the stale limit force the rate to 0; a tick whose timestamp did not move
// forward keeps the previous rate. A clear transfer (tuser set) empties the
// ring and returns zeros. One item is worked at a time: a tick that needs a
// division runs the serial divider and then scans the ring for the peak one
// entry after another through the single memory read port, a tick without
// division only scans, and a clear does neither. The next item is
// taken while the previous result still waits in the output register. Write
// the stale limit only while the block is idle.
module counter_rate_window_peak #(
  parameter int WINDOW_DEPTH = 100
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // stale limit write channel
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [15:0]   cfg_data,     // stale_limit_ms
  // input stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [111:0]  s_axis_tdata,  // sample_time, now_time, counter_value
  input  wire logic [0:0]    s_axis_tuser,  // mode
  // result stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [71:0]        m_axis_tdata   // rate, window_peak, zero pad
);
  import crwp_pkg::*;

  crwp_cmd_t    cmd;
  crwp_status_t status;

  logic [RATE_W-1:0] out_rate;
  logic [PEAK_W-1:0] out_peak;

  // register writes complete at once, closed while reset is held
  assign cfg_ready = ~rst;

  crwp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  crwp_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid),
    .cfg_limit (cfg_data),
    .in_mode   (s_axis_tuser[0]),
    .in_sample (s_axis_tdata[31:0]),
    .in_now    (s_axis_tdata[63:32]),
    .in_value  (s_axis_tdata[111:64]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rate  (out_rate),
    .out_peak  (out_peak)
  );

  assign m_axis_tdata = {1'b0, out_peak, out_rate};

`ifndef SYNTHESIS
  // one item at a time: an accepted transfer closes the input until done
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // the divider goes busy right after it is started
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("divider did not start");

  // the current rate is part of the window, so the peak covers it
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[39]) |->
      ({m_axis_tdata[70:40], 8'hff} >= m_axis_tdata[38:0]))
    else $error("window peak below current rate");
`endif

endmodule

`default_nettype wire

FILE: sv/crwp_div.sv
// serial restoring divider: rate = 256000 * magnitude / elapsed, saturated
// one quotient bit per cycle; uses crwp_pkg
`timescale 1ns / 1ps
`default_nettype none

module crwp_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [crwp_pkg::COUNT_W-1:0]      mag,
  input  wire logic                              neg,
  input  wire logic [crwp_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                   done,
  output logic signed [crwp_pkg::RATE_W-1:0]     quotient
);
  import crwp_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]     dividend;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [RATE_W-1:0]    q;
  logic                 ovf;
  logic                 neg_r;
  logic                 busy;
  logic [CNT_W-1:0]     count;

  logic [SCALED_W-1:0]  mag_ext;
  logic [SCALED_W-1:0]  scaled;
  logic [DIVISOR_W:0]   rem_shift;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;
  logic                 sat;

  // magnitude times 125
  assign mag_ext = SCALED_W'(mag);
  assign scaled  = (mag_ext << 7) - (mag_ext << 2) + mag_ext;

  assign rem_shift = {rem, dividend[DVD_W-1]};
  assign diff      = rem_shift - {1'b0, dsr};
  assign ge        = ~diff[DIVISOR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(DVD_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {scaled, {SCALE_SHIFT{1'b0}}};
      rem      <= '0;
      dsr      <= divisor;
      q        <= '0;
      ovf      <= 1'b0;
      neg_r    <= neg;
    end else if (busy) begin
      dividend <= dividend << 1;
      rem      <= ge ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      q        <= {q[RATE_W-2:0], ge};
      ovf      <= ovf | q[RATE_W-1];
    end
  end

  assign done = ~busy;
  assign sat  = ovf | q[RATE_W-1];

  always_comb begin
    if (neg_r) begin
      quotient = sat ? RATE_MIN : -$signed(q);
    end else begin
      quotient = sat ? RATE_MAX : $signed(q);
    end
  end

endmodule

`default_nettype wire

FILE: sv/crwp_ctrl.sv
// sequencer for one item: evaluate, divide when needed, write ring and scan (not for a clear), present result
// drives crwp_cmd_t and reads crwp_status_t from crwp_pkg
`timescale 1ns / 1ps
`default_nettype none

module crwp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire crwp_pkg::crwp_status_t status,
  output crwp_pkg::crwp_cmd_t        cmd
);
  import crwp_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    EVAL,
    DIV_START,
    DIVIDE,
    WRITE,
    SCAN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        // closed while reset is held
        in_ready = ~rst;
        if (in_valid && ~rst) begin
          cmd.load   = 1'b1;
          state_next = EVAL;
        end
      end
      EVAL: begin
        cmd.eval = 1'b1;
        if (status.is_clear) begin
          state_next = FINISH;
        end else if (status.need_div) begin
          state_next = DIV_START;
        end else begin
          state_next = WRITE;
        end
      end
      DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = DIVIDE;
      end
      DIVIDE: begin
        if (status.div_done) begin
          cmd.rate_from_div = 1'b1;
          state_next        = WRITE;
        end
      end
      WRITE: begin
        cmd.ring_write = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = SCAN;
      end
      SCAN: begin
        if (status.scan_done) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crwp_datapath.sv
// datapath: item registers, rate state, history ring memory, peak scan, output register
// uses crwp_pkg and instantiates crwp_div
`timescale 1ns / 1ps
`default_nettype none

module crwp_datapath #(
  parameter int WINDOW_DEPTH = 100
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire crwp_pkg::crwp_cmd_t               cmd,
  output crwp_pkg::crwp_status_t                 status,
  input  wire logic                              cfg_we,
  input  wire logic [crwp_pkg::LIMIT_W-1:0]      cfg_limit,
  input  wire logic                              in_mode,
  input  wire logic [crwp_pkg::TIME_W-1:0]       in_sample,
  input  wire logic [crwp_pkg::TIME_W-1:0]       in_now,
  input  wire logic [crwp_pkg::COUNT_W-1:0]      in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [crwp_pkg::RATE_W-1:0]            out_rate,
  output logic [crwp_pkg::PEAK_W-1:0]            out_peak
);
  import crwp_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0] FULL     = FW'(WINDOW_DEPTH);

  // configuration and carried state
  logic [LIMIT_W-1:0]       stale_limit;
  logic [AW-1:0]            wp;
  logic [TIME_W-1:0]        prev_time;
  logic [COUNT_W-1:0]       prev_count;
  logic signed [RATE_W-1:0] rate;

  // captured item
  logic               mode_r;
  logic [TIME_W-1:0]  sample_r;
  logic [TIME_W-1:0]  now_r;
  logic [COUNT_W-1:0] value_r;

  // divider operands
  logic [COUNT_W-1:0]   mag;
  logic                 mag_neg;
  logic [DIVISOR_W-1:0] elapsed_r;
  logic                 div_done;
  logic signed [RATE_W-1:0] div_rate;

  // history ring
  logic [RATE_W-1:0] ring [WINDOW_DEPTH];
  logic [FW-1:0]     fill;

  // scan
  logic [AW-1:0]            scan_addr;
  logic                     issuing;
  logic                     rd_live;
  logic                     rd_ok;
  logic [RATE_W-1:0]        rd_data;
  logic signed [RATE_W-1:0] best;
  logic signed [RATE_W-1:0] rd_entry;

  logic [TIME_W-1:0]  age;
  logic [TIME_W-1:0]  elapsed;
  logic               stale;
  logic               el_ok;
  logic               prev_zero;
  logic [RATE_W:0]    ceil_sum;
  logic [PEAK_W-1:0]  peak_calc;

  assign age       = now_r - sample_r;
  assign elapsed   = sample_r - prev_time;
  // negative age never counts as stale
  assign stale     = ~age[TIME_W-1] && (age > TIME_W'(stale_limit));
  assign el_ok     = (elapsed != '0) && ~elapsed[TIME_W-1];
  assign prev_zero = (prev_count == '0);

  assign status.is_clear  = mode_r;
  assign status.need_div  = ~mode_r && ~stale && el_ok && ~prev_zero;
  assign status.div_done  = div_done;
  assign status.scan_done = ~issuing && ~rd_live;
  assign status.out_free  = ~out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_RESET;
    end else if (cfg_we) begin
      stale_limit <= cfg_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      sample_r <= in_sample;
      now_r    <= in_now;
      value_r  <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      prev_time  <= '0;
      prev_count <= '0;
      rate       <= '0;
      fill       <= '0;
    end else begin
      if (cmd.eval) begin
        prev_time <= sample_r;
        if (mode_r) begin
          wp         <= '0;
          prev_count <= '0;
          rate       <= '0;
          fill       <= '0;
        end else begin
          wp         <= (wp >= LAST_POS) ? '0 : wp + 1'b1;
          prev_count <= value_r;
          if (stale || (el_ok && prev_zero)) begin
            rate <= '0;
          end
        end
      end
      if (cmd.rate_from_div) begin
        rate <= div_rate;
      end
      if (cmd.ring_write && (fill != FULL)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // counter difference as sign and magnitude
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      mag_neg   <= value_r < prev_count;
      mag       <= (value_r < prev_count) ? prev_count - value_r : value_r - prev_count;
      elapsed_r <= elapsed[DIVISOR_W-1:0];
    end
  end

  crwp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .mag      (mag),
    .neg      (mag_neg),
    .divisor  (elapsed_r),
    .done     (div_done),
    .quotient (div_rate)
  );

  // since a clear, writes land on positions 1, 2, ... and position 0 comes last
  always_ff @(posedge clk) begin
    if (cmd.ring_write) begin
      ring[wp] <= rate;
    end
    if (issuing) begin
      rd_data <= ring[scan_addr];
      rd_ok   <= (fill == FULL) || ((scan_addr != '0) && (FW'(scan_addr) <= fill));
    end
  end

  // never-written entries read as zero
  assign rd_entry = rd_ok ? $signed(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_live <= 1'b0;
    end else if (cmd.scan_start) begin
      issuing <= 1'b1;
      rd_live <= 1'b0;
    end else begin
      rd_live <= issuing;
      if (issuing && (scan_addr == LAST_POS)) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
      best      <= RATE_MIN;
    end else begin
      if (issuing) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (rd_live && (rd_entry > best)) begin
        best <= rd_entry;
      end
    end
  end

  // ceiling of best / 256, clamped to the output range
  assign ceil_sum = {best[RATE_W-1], best} + (RATE_W+1)'(255);

  always_comb begin
    if (best[RATE_W-1] || (best == '0)) begin
      peak_calc = '0;
    end else if (ceil_sum[RATE_W:PEAK_W+8] != '0) begin
      peak_calc = PEAK_MAX;
    end else begin
      peak_calc = ceil_sum[PEAK_W+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rate <= mode_r ? '0 : rate;
      out_peak <= mode_r ? '0 : peak_calc;
    end
  end

endmodule

`default_nettype wire
